// ----- sv/grie_pkg.sv -----
// Shared constants and types for the glass refractive index evaluator.
package grie_pkg;

    // Dispersion model codes
    localparam logic [1:0] MODE_SELL   = 2'd0;
    localparam logic [1:0] MODE_SERIES = 2'd1;
    localparam logic [1:0] MODE_CONST  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MODEL = 3'd0;
    localparam logic [2:0] REG_STR1  = 3'd1;
    localparam logic [2:0] REG_STR2  = 3'd2;
    localparam logic [2:0] REG_STR3  = 3'd3;
    localparam logic [2:0] REG_POLE1 = 3'd4;
    localparam logic [2:0] REG_POLE2 = 3'd5;
    localparam logic [2:0] REG_POLE3 = 3'd6;

    // Divider geometry: 96-bit dividend, 57-bit divisor, 42 quotient bits
    localparam int NUM_W   = 96;
    localparam int DEN_W   = 57;
    localparam int QB      = 42;
    localparam int DIV_LAT = QB + 1;

    // Square root: one result bit per stage
    localparam int SQ_STEPS = 32;

    localparam logic [31:0]        MICRO   = 32'd1000000;
    localparam logic signed [20:0] MICRO_S = 21'sd1000000;
    localparam logic [QB-1:0]      QCLAMP  = {1'b1, {(QB-1){1'b0}}};

    // Sideband that rides alongside the dividers
    typedef struct packed {
        logic       valid;
        logic       err;
        logic [2:0] neg;
    } t_dside;

endpackage

// ----- sv/grie_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, quotient clamped to 2^41.
module grie_div
(
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [grie_pkg::NUM_W-1:0]  i_num,
    input  logic [grie_pkg::DEN_W-1:0]  i_den,
    output logic [grie_pkg::QB-1:0]     o_quot
);
    import grie_pkg::*;

    logic [DEN_W-1:0] r_rem [0:QB];
    logic [DEN_W-1:0] r_den [0:QB];
    logic [QB-1:0]    r_low [0:QB];
    logic [QB-1:0]    r_quo [0:QB];
    logic             r_ovf [0:QB];

    // Entry stage: a quotient of 2^42 or more only ever clamps
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= {3'b000, i_num} >= {i_den, {QB{1'b0}}};
            r_rem[0] <= DEN_W'(i_num[NUM_W-1:QB]);
            r_low[0] <= i_num[QB-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    // One compare and subtract per stage
    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [DEN_W:0] n_trial;
        logic           n_ge;
        assign n_trial = {r_rem[k-1], r_low[k-1][QB-1]};
        assign n_ge    = n_trial >= {1'b0, r_den[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? DEN_W'(n_trial - {1'b0, r_den[k-1]})
                                 : n_trial[DEN_W-1:0];
                r_low[k] <= {r_low[k-1][QB-2:0], 1'b0};
                r_quo[k] <= {r_quo[k-1][QB-2:0], n_ge};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quot = (r_ovf[QB] || r_quo[QB] > QCLAMP) ? QCLAMP : r_quo[QB];

endmodule

// ----- sv/glass_refractive_index_eval_core.sv -----
// Top level of the glass refractive index evaluator.
// Converts a wavelength in nm to a glass refractive index (unsigned Q4.28) by the
// three-term Sellmeier equation, a two-term power series or a constant, as
// the model register chooses. One wavelength is taken every cycle unless the output
// stalls; each result passes the 43-stage dividers (one quotient bit per stage) and the
// 32-stage square root (one root bit per stage). The dividers run side by side for
// the three terms. A stalled output holds the whole pipeline. Domain faults give all
// ones with domain_error set; an index of 16 or more gives all ones alone.
// The user must write configuration only while no beat is in flight (not enforced).
module glass_refractive_index_eval_core
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_wavelength_nm,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_refractive_index,
    output logic        o_domain_error
);
    import grie_pkg::*;

    typedef struct packed {
        logic        valid;
        logic        err;
        logic        ones;
        logic        byp;
        logic [31:0] bval;
    } t_sside;

    // Configuration registers
    logic [1:0]         r_model;
    logic signed [31:0] r_str  [3];
    logic signed [31:0] r_pole [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= MODE_SELL;
            for (int i = 0; i < 3; i++) begin
                r_str[i]  <= '0;
                r_pole[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODEL: r_model   <= i_cfg_data[1:0];
                REG_STR1:  r_str[0]  <= i_cfg_data;
                REG_STR2:  r_str[1]  <= i_cfg_data;
                REG_STR3:  r_str[2]  <= i_cfg_data;
                REG_POLE1: r_pole[0] <= i_cfg_data;
                REG_POLE2: r_pole[1] <= i_cfg_data;
                REG_POLE3: r_pole[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Global advance: moves whenever the output register is free or being taken
    logic r_out_valid;
    logic en;
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    // Stage 1: capture beat; stage 2: square the wavelength
    logic        r_p1_valid, r_p2_valid, r_p3_valid, r_p4_valid;
    logic [15:0] r_p1_wl;
    logic [31:0] r_p2_w, r_p3_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid <= i_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_wl <= i_wavelength_nm;
            r_p2_w  <= 32'(r_p1_wl) * 32'(r_p1_wl);
            r_p3_w  <= r_p2_w;
        end
    end

    // Stage 3: coefficient magnitudes times w (or 10^6), poles times 10^6
    logic [31:0]        n_mag  [3];
    logic [31:0]        n_opnd [3];
    logic [63:0]        n_prod [3];
    logic signed [52:0] n_bm   [3];
    logic [63:0]        r_p3_prod [3];
    logic signed [52:0] r_p3_bm   [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i]  = r_str[i][31] ? 32'(-r_str[i]) : r_str[i];
            n_opnd[i] = (r_model == MODE_SERIES && i == 2) ? MICRO : r_p2_w;
            n_prod[i] = 64'(n_mag[i]) * 64'(n_opnd[i]);
            n_bm[i]   = 53'(r_pole[i]) * 53'(MICRO_S);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p3_prod[i] <= n_prod[i];
                r_p3_bm[i]   <= n_bm[i];
            end
        end
    end

    // Stage 4: dividend, divisor and quotient sign for each term
    logic signed [57:0] n_d   [3];
    logic [NUM_W-1:0]   n_num [3];
    logic [DEN_W-1:0]   n_den [3];
    logic [2:0]         n_neg;
    logic               n_err;
    logic [NUM_W-1:0]   r_p4_num [3];
    logic [DEN_W-1:0]   r_p4_den [3];
    logic [2:0]         r_p4_neg;
    logic               r_p4_err;

    always_comb begin
        n_err = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_d[i] = $signed({2'b00, r_p3_w, 24'b0}) - 58'(r_p3_bm[i]);
            if (r_model == MODE_SERIES) begin
                n_num[i] = {24'b0, r_p3_prod[i], 8'b0};
                n_den[i] = (i == 2) ? DEN_W'(r_p3_w) : DEN_W'(MICRO);
                n_neg[i] = r_str[i][31];
            end else begin
                n_num[i] = {r_p3_prod[i], 32'b0};
                n_den[i] = n_d[i][57] ? DEN_W'(-n_d[i]) : n_d[i][DEN_W-1:0];
                n_neg[i] = r_str[i][31] ^ n_d[i][57];
                if (r_model == MODE_SELL && n_d[i] == '0)
                    n_err = 1'b1;
            end
        end
        if (r_model == MODE_SERIES && r_p3_w == '0)
            n_err = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_p4_num[i] <= n_num[i];
                r_p4_den[i] <= n_den[i];
            end
            r_p4_neg <= n_neg;
            r_p4_err <= n_err;
        end
    end

    // Three dividers in parallel
    logic [QB-1:0] w_quot [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        grie_div u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_p4_num[i]),
            .i_den  (r_p4_den[i]),
            .o_quot (w_quot[i])
        );
    end

    // Sideband matched to divider latency
    t_dside r_dside [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++)
                r_dside[k] <= '0;
        end else if (en) begin
            r_dside[0] <= '{valid: r_p4_valid, err: r_p4_err, neg: r_p4_neg};
            for (int k = 1; k < DIV_LAT; k++)
                r_dside[k] <= r_dside[k-1];
        end
    end

    // Stage 5: signed terms; stage 6: pairwise sums; stage 7: radicand
    logic signed [47:0] n_term [3];
    logic signed [47:0] r_p5_term [3];
    logic signed [47:0] n_base;
    logic signed [47:0] r_p6_s01, r_p6_s12, r_p7_rad;
    t_dside             r_p5_side, r_p6_side, r_p7_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_model == MODE_SERIES && i == 0)
                n_term[i] = '0;
            else if (r_dside[DIV_LAT-1].neg[i])
                n_term[i] = -$signed({6'b0, w_quot[i]});
            else
                n_term[i] = $signed({6'b0, w_quot[i]});
        end
        if (r_model == MODE_SERIES)
            n_base = $signed({{8{r_str[0][31]}}, r_str[0], 8'b0});
        else
            n_base = 48'sh0001_0000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_side <= '0;
            r_p6_side <= '0;
            r_p7_side <= '0;
        end else if (en) begin
            r_p5_side <= r_dside[DIV_LAT-1];
            r_p6_side <= r_p5_side;
            r_p7_side <= r_p6_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++)
                r_p5_term[i] <= n_term[i];
            r_p6_s01 <= n_base + r_p5_term[0];
            r_p6_s12 <= r_p5_term[1] + r_p5_term[2];
            r_p7_rad <= r_p6_s01 + r_p6_s12;
        end
    end

    // Stage 8: classify and set up the square root (feeds sqrt slot 0)
    t_sside      n_cls;
    t_sside      r_sside  [SQ_STEPS+1];
    logic [63:0] r_sq_x   [SQ_STEPS+1];
    logic [33:0] r_sq_rem [SQ_STEPS+1];
    logic [31:0] r_sq_root[SQ_STEPS+1];

    always_comb begin
        n_cls       = '0;
        n_cls.valid = r_p7_side.valid;
        case (r_model)
            MODE_SELL, MODE_SERIES: begin
                n_cls.err  = r_p7_side.err || r_p7_rad[47];
                n_cls.ones = n_cls.err || (|r_p7_rad[46:40]);
            end
            MODE_CONST: begin
                n_cls.byp = 1'b1;
                if (r_str[0][31])
                    n_cls.bval = '0;
                else if (|r_str[0][30:28])
                    n_cls.bval = '1;
                else
                    n_cls.bval = {r_str[0][27:0], 4'b0};
            end
            default: begin
                n_cls.err  = 1'b1;
                n_cls.ones = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sside[0] <= '0;
        end else if (en) begin
            r_sside[0] <= n_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_x[0]    <= {r_p7_rad[39:0], 24'b0};
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    // Square root, one root bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [35:0] n_acc;
        logic [35:0] n_try;
        logic        n_ge;
        assign n_acc = {r_sq_rem[k], r_sq_x[k][63:62]};
        assign n_try = {2'b00, r_sq_root[k], 2'b01};
        assign n_ge  = n_acc >= n_try;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sside[k+1] <= '0;
            end else if (en) begin
                r_sside[k+1] <= r_sside[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k+1]  <= n_ge ? 34'(n_acc - n_try) : n_acc[33:0];
                r_sq_root[k+1] <= {r_sq_root[k][30:0], n_ge};
                r_sq_x[k+1]    <= {r_sq_x[k][61:0], 2'b00};
            end
        end
    end

    // Output register
    logic [31:0] r_out_idx;
    logic        r_out_err;
    t_sside      w_last;
    assign w_last = r_sside[SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_err <= w_last.err;
            if (w_last.ones)
                r_out_idx <= '1;
            else if (w_last.byp)
                r_out_idx <= w_last.bval;
            else
                r_out_idx <= r_sq_root[SQ_STEPS];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_refractive_index = r_out_idx;
    assign o_domain_error     = r_out_err;

endmodule

// ----- sim/glass_refractive_index_eval_core_tb.sv -----
// Testbench for the glass refractive index evaluator: directed and random beats, scoreboard check.
module glass_refractive_index_eval_core_tb;
    import grie_pkg::*;

    localparam int LATENCY   = 84;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1700;

    typedef struct {
        logic [31:0] index;
        logic        derr;
    } t_index_result;

    // Model registers kept alongside the block
    logic [1:0]  m_model;
    logic [31:0] m_str [1:3];
    logic [31:0] m_pole [1:3];

    // Directed stimulus lists
    logic [15:0] sell_wls   [6] = '{16'd0, 16'd1, 16'd587, 16'd1000, 16'd1550, 16'hFFFF};
    logic [15:0] series_wls [4] = '{16'd0, 16'd1, 16'd400, 16'hFFFF};
    logic [31:0] const_vals [5] = '{32'h0180_0000, 32'h8000_0000, 32'h1000_0000,
                                    32'h7FFF_FFFF, 32'h0FFF_FFFF};

    // floor(mag*2^sh/den), clamped at 2^41
    function automatic logic [63:0] clamped_quot(logic [63:0] mag, int sh, logic [63:0] den);
        logic [127:0] num;
        logic [127:0] q;
        num = {64'd0, mag} << sh;
        q = num / {64'd0, den};
        if (q > 128'h200_0000_0000) return 64'h200_0000_0000;
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] apply_sign(bit neg, logic [63:0] q);
        return neg ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] mag_of(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        for (int i = 31; i >= 0; i--) begin
            b = r | (64'd1 << i);
            if (b * b <= x && b < 64'h1_0000_0000) r = b;
        end
        return r;
    endfunction

    function automatic t_index_result predict_index(logic [15:0] wl);
        t_index_result res;
        logic [63:0] w;
        logic signed [63:0] rad, a, d, c;
        bit err;
        w = 64'(wl) * 64'(wl);
        rad = 0;
        err = 0;
        res.derr = 0;
        if (m_model == MODE_SELL) begin
            rad = 64'sh1_0000_0000;
            for (int i = 1; i <= 3; i++) begin
                a = $signed(m_str[i]);
                d = $signed(w << 24) - $signed(m_pole[i]) * 64'sd1000000;
                if (d == 0) begin
                    err = 1;
                    break;
                end
                rad += apply_sign((a < 0) != (d < 0),
                                  clamped_quot(mag_of(a) * w, 32, mag_of(d)));
            end
        end else if (m_model == MODE_SERIES) begin
            if (w == 0) begin
                err = 1;
            end else begin
                rad = $signed(m_str[1]) * 64'sd256;
                a = $signed(m_str[2]);
                rad += apply_sign(a < 0, clamped_quot(mag_of(a) * w, 8, 64'd1000000));
                a = $signed(m_str[3]);
                rad += apply_sign(a < 0, clamped_quot(mag_of(a) * 64'd1000000, 8, w));
            end
        end else if (m_model == MODE_CONST) begin
            c = $signed(m_str[1]);
            if (c < 0) res.index = 0;
            else if (c >= (64'sd16 <<< 24)) res.index = '1;
            else res.index = m_str[1] << 4;
            return res;
        end else begin
            err = 1;
        end
        if (!err && rad < 0) err = 1;
        if (err) begin
            res.index = '1;
            res.derr = 1;
        end else if (rad >= (64'sd1 <<< 40)) begin
            res.index = '1;
        end else begin
            res.index = int_sqrt(rad << 24);
        end
        return res;
    endfunction

    class index_scoreboard;
        t_index_result pending[$];
        int errors;

        function void note_wavelength(logic [15:0] wl);
            pending.push_back(predict_index(wl));
        endfunction

        function void check_index(logic [31:0] idx, logic derr);
            t_index_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat idx=%h err=%b", $time, idx, derr);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (idx !== e.index) begin
                $display("%0t: refractive_index expected %h actual %h", $time, e.index, idx);
                errors++;
            end
            if (derr !== e.derr) begin
                $display("%0t: domain_error expected %b actual %b", $time, e.derr, derr);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [15:0] i_wavelength_nm = '0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [31:0] o_refractive_index;
    logic        o_domain_error;

    index_scoreboard sb = new();
    bit   calm = 0;   // long stretch without idling
    int   quiet_cycles = 0;

    glass_refractive_index_eval_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Sample results and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_index(o_refractive_index, o_domain_error);
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WDOG_MAX) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Random output stall
    always @(negedge i_clk)
        i_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_MODEL: m_model = val[1:0];
            REG_STR1:  m_str[1] = val;
            REG_STR2:  m_str[2] = val;
            REG_STR3:  m_str[3] = val;
            REG_POLE1: m_pole[1] = val;
            REG_POLE2: m_pole[2] = val;
            REG_POLE3: m_pole[3] = val;
            default: ;
        endcase
    endtask

    // Send one beat; caller is at a falling edge
    task automatic send_wavelength(logic [15:0] wl);
        while (!calm && $urandom_range(99) < 33) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_wavelength_nm <= wl;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_wavelength(wl);
        @(negedge i_clk);
    endtask

    // Caller is at a falling edge right after its last beat
    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_wl();
        case ($urandom_range(5))
            0: return 16'($urandom_range(1, 3));
            1: return 16'(16'hFFFF - $urandom_range(3));
            2: return 16'($urandom_range(300, 2500));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 32'h0200_0000);
            3: return -$urandom_range(0, 32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    // Glass-like Sellmeier set with a pole placed exactly on wl=1000
    task automatic load_sellmeier_glass();
        write_reg(REG_MODEL, 32'(MODE_SELL));
        write_reg(REG_STR1, 32'h0105_4CD0);
        write_reg(REG_STR2, 32'h0036_0A9F);
        write_reg(REG_STR3, 32'h0101_2F79);
        write_reg(REG_POLE1, 32'h0001_8A17);
        write_reg(REG_POLE2, 32'h0001_0000 << 8);  // 1.0 um^2
        write_reg(REG_POLE3, 32'h6789_ABCD);
    endtask

    initial begin
        m_model = 0;
        for (int i = 1; i <= 3; i++) begin
            m_str[i] = 0;
            m_pole[i] = 0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: reset coefficients, then each model at its edges
        send_wavelength(16'd0);
        send_wavelength(16'hFFFF);
        drain();
        load_sellmeier_glass();
        foreach (sell_wls[k])
            send_wavelength(sell_wls[k]);
        drain();
        write_reg(REG_STR1, 32'h8000_0000);   // negative radicand
        send_wavelength(16'd700);
        drain();
        write_reg(REG_MODEL, 32'(MODE_SERIES));
        write_reg(REG_STR1, 32'h0250_0000);
        write_reg(REG_STR2, 32'hFFF0_0000);
        write_reg(REG_STR3, 32'h0001_0000);
        foreach (series_wls[k])
            send_wavelength(series_wls[k]);
        drain();
        write_reg(REG_STR1, 32'h7FFF_FFFF);   // large constant term, index below 16
        send_wavelength(16'd500);
        drain();
        write_reg(REG_MODEL, 32'(MODE_CONST));
        foreach (const_vals[k]) begin
            write_reg(REG_STR1, const_vals[k]);
            send_wavelength(16'($urandom));
            drain();
        end
        write_reg(REG_MODEL, 32'd3);          // unused model code
        send_wavelength(16'd633);
        drain();
        write_reg(3'd7, 32'hDEAD_BEEF);       // index past the list is ignored

        // Random phases
        for (int ph = 0; ph < 17; ph++) begin
            calm = (ph == 5);
            if (ph % 4 == 0) begin
                load_sellmeier_glass();
            end else begin
                write_reg(REG_MODEL, (ph % 8 == 7) ? 32'd3 : 32'($urandom_range(2)));
                for (int r = 1; r <= 6; r++) write_reg(r[2:0], pick_coef());
            end
            for (int n = 0; n < N_RANDOM / 17; n++) send_wavelength(pick_wl());
            drain();
        end
        calm = 0;

        if (sb.errors == 0 && sb.pending.size() == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
